// ===== rtl/pmvg_pkg.sv =====
// Package: shared constants, types and tables for the parametric mesh vertex generator.
package pmvg_pkg;

  localparam int MaxPrecision = 255;
  localparam int AngleBits    = 16;
  localparam int CordicSteps  = 20;
  localparam int DivSteps     = 24;

  localparam logic signed [33:0] CordicSeed = 34'sd652032874;

  localparam logic [3:0] CfgShapeMode = 4'd0;
  localparam logic [3:0] CfgPrecision = 4'd1;
  localparam logic [3:0] CfgInnerRad  = 4'd2;
  localparam logic [3:0] CfgRingRad   = 4'd3;

  // Arctangent of 2^-k in units of 2^32 per turn.
  function automatic logic signed [33:0] atan_turn(input int k);
    logic signed [33:0] t;
    begin
      unique case (k)
        0:  t = 34'sh20000000;
        1:  t = 34'sh12E4051D;
        2:  t = 34'sh09FB385B;
        3:  t = 34'sh051111D4;
        4:  t = 34'sh028B0D43;
        5:  t = 34'sh0145D7E1;
        6:  t = 34'sh00A2F61E;
        7:  t = 34'sh00517C55;
        8:  t = 34'sh0028BE53;
        9:  t = 34'sh00145F2E;
        10: t = 34'sh000A2F98;
        11: t = 34'sh000517CC;
        12: t = 34'sh00028BE6;
        13: t = 34'sh000145F3;
        14: t = 34'sh0000A2F9;
        15: t = 34'sh0000517C;
        16: t = 34'sh000028BE;
        17: t = 34'sh0000145F;
        18: t = 34'sh00000A2F;
        default: t = 34'sh00000517;
      endcase
      return t;
    end
  endfunction

  // Per-item control that rides along the pipeline.
  typedef struct packed {
    logic        mode;
    logic [7:0]  prec;
    logic [14:0] inner;
    logic [14:0] ring;
    logic [7:0]  row;
    logic [7:0]  col;
  } item_t;

endpackage

// ===== rtl/pmvg_div.sv =====
// Pipelined restoring divider: quotient = (num + den/2) / den, one quotient bit per stage.
module pmvg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [23:0] num_i,
  input  logic [7:0]  den_i,
  output logic [23:0] quo_o
);
  localparam int N = pmvg_pkg::DivSteps;

  logic [N-1:0][24:0] num_q;
  logic [N-1:0][23:0] quo_q;
  logic [N-1:0][8:0]  rem_q;
  logic [N-1:0][7:0]  den_q;

  logic [N-1:0][8:0]  rem_d;
  logic [N-1:0][23:0] quo_d;

  // Stage s consumes numerator bit N-1-s.
  always_comb begin
    for (int s = 0; s < N; s++) begin
      logic [8:0]  r;
      logic [24:0] n;
      logic [23:0] qq;
      logic [7:0]  d;
      if (s == 0) begin
        n  = {1'b0, num_i} + {17'd0, 1'b0, den_i[7:1]};
        r  = 9'd0;
        qq = 24'd0;
        d  = den_i;
      end else begin
        n  = num_q[s-1];
        r  = rem_q[s-1];
        qq = quo_q[s-1];
        d  = den_q[s-1];
      end
      r = {r[7:0], n[N-1-s]};
      // Top bit of the rounded numerator lands in stage 0 via bit 24.
      if (s == 0) r = {7'd0, n[24], n[N-1]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        qq[N-1-s] = 1'b1;
      end else begin
        qq[N-1-s] = 1'b0;
      end
      rem_d[s] = r;
      quo_d[s] = qq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        if (s == 0) begin
          num_q[s] <= {1'b0, num_i} + {17'd0, 1'b0, den_i[7:1]};
          den_q[s] <= den_i;
        end else begin
          num_q[s] <= num_q[s-1];
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign quo_o = quo_q[N-1];

`ifndef ASSERT_OFF
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> den_q[0] != 8'd0) else $error("divider saw zero divisor");
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> rem_q[0] < {1'b0, den_q[0]}) else $error("remainder not below divisor");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(quo_q[N-1])) else $error("divider moved while stalled");
`endif
endmodule

// ===== rtl/pmvg_cordic.sv =====
// Pipelined rotation-mode CORDIC: cosine and sine in Q.30 of a 32-bit phase.
module pmvg_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  localparam int N = pmvg_pkg::CordicSteps;

  logic [N-1:0][1:0]         quad_q;
  logic signed [33:0]        x_q [N];
  logic signed [33:0]        y_q [N];
  logic signed [33:0]        z_q [N];
  logic signed [33:0]        x_d [N];
  logic signed [33:0]        y_d [N];
  logic signed [33:0]        z_d [N];

  logic [1:0]  quad;
  logic [31:0] resid;
  logic [31:0] ph_off;

  assign ph_off = phase_i + 32'h20000000;
  assign quad   = ph_off[31:30];
  assign resid  = phase_i - {quad, 30'd0};

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic signed [33:0] x, y, z;
      if (k == 0) begin
        x = pmvg_pkg::CordicSeed;
        y = '0;
        z = {{2{resid[31]}}, resid};
      end else begin
        x = x_q[k-1];
        y = y_q[k-1];
        z = z_q[k-1];
      end
      if (!z[33]) begin
        x_d[k] = x - (y >>> k);
        y_d[k] = y + (x >>> k);
        z_d[k] = z - pmvg_pkg::atan_turn(k);
      end else begin
        x_d[k] = x + (y >>> k);
        y_d[k] = y - (x >>> k);
        z_d[k] = z + pmvg_pkg::atan_turn(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
        quad_q[k] <= (k == 0) ? quad : quad_q[k-1];
      end
    end
  end

  always_comb begin
    unique case (quad_q[N-1])
      2'd0: begin cos_o = x_q[N-1];  sin_o = y_q[N-1];  end
      2'd1: begin cos_o = -y_q[N-1]; sin_o = x_q[N-1];  end
      2'd2: begin cos_o = -x_q[N-1]; sin_o = -y_q[N-1]; end
      default: begin cos_o = y_q[N-1]; sin_o = -x_q[N-1]; end
    endcase
  end

`ifndef ASSERT_OFF
  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> x_q[0] > 34'sd0) else $error("cordic first stage lost seed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(x_q[N-1]) && $stable(y_q[N-1])) else $error("cordic moved stalled");
  a_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(quad_q[N-1])) else $error("quadrant moved stalled");
`endif
endmodule

// ===== rtl/pmvg_post.sv =====
// Output math: products, rounding, saturation and index arithmetic, three register stages.
module pmvg_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  pmvg_pkg::item_t    item_i,
  input  logic signed [33:0] c1_i,
  input  logic signed [33:0] s1_i,
  input  logic signed [33:0] c2_i,
  input  logic signed [33:0] s2_i,
  input  logic [23:0]        tu_i,
  input  logic [23:0]        tv_i,
  output logic [167:0]       res_o,
  output logic               qv_o
);
  // Stage A: first products.
  pmvg_pkg::item_t a_item_q, b_item_q;
  logic signed [67:0] a_p1_q, a_p2_q;   // -s1*c2, s1*s2 or c2*c1, c2*s1
  logic signed [49:0] a_rc_q, a_rs_q;   // r*c2, r*s2
  logic signed [33:0] a_c1_q, a_s1_q, a_s2_q;
  logic [16:0] a_tu_q, a_tv_q, b_tu_q, b_tv_q;

  logic signed [67:0] b_px_q, b_pz_q;
  logic signed [15:0] b_nx_q, b_ny_q, b_nz_q, b_py_q;
  logic [15:0] b_vi_q, b_nr_q;
  logic        b_qv_q;

  logic signed [67:0] mula, mulb;
  logic [16:0] tu_sat, tv_sat;

  function automatic logic signed [15:0] sat(input logic signed [67:0] v,
                                             input logic signed [16:0] lo,
                                             input logic signed [16:0] hi);
    logic signed [67:0] l, h;
    begin
      l = 68'(lo);
      h = 68'(hi);
      if (v < l) return lo[15:0];
      if (v > h) return hi[15:0];
      return v[15:0];
    end
  endfunction

  function automatic logic signed [67:0] rsh(input logic signed [67:0] v, input int s);
    logic signed [67:0] one;
    begin
      one = 68'sd1 <<< (s - 1);
      return (v + one) >>> s;
    end
  endfunction

  assign tu_sat = (tu_i > 24'd65536) ? 17'd65536 : tu_i[16:0];
  assign tv_sat = (tv_i > 24'd65536) ? 17'd65536 : tv_i[16:0];

  always_comb begin
    if (!item_i.mode) begin
      mula = -(68'(s1_i) * 68'(c2_i));
      mulb = 68'(s1_i) * 68'(s2_i);
    end else begin
      mula = 68'(c2_i) * 68'(c1_i);
      mulb = 68'(c2_i) * 68'(s1_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q <= item_i;
      a_p1_q   <= mula;
      a_p2_q   <= mulb;
      a_rc_q   <= 50'($signed({1'b0, item_i.ring})) * 50'(c2_i);
      a_rs_q   <= 50'($signed({1'b0, item_i.ring})) * 50'(s2_i);
      a_c1_q   <= c1_i;
      a_s1_q   <= s1_i;
      a_s2_q   <= s2_i;
      a_tu_q   <= tu_sat;
      a_tv_q   <= tv_sat;
    end
  end

  // Stage B: torus w, normals, y, indices.
  logic signed [67:0] w_full, w_r;
  logic [16:0] pp1;
  logic [15:0] vi;

  assign w_full = (68'($signed({1'b0, a_item_q.inner})) <<< 30) + 68'(a_rc_q);
  assign w_r    = rsh(w_full, 18);
  assign pp1    = {9'd0, a_item_q.prec} + 17'd1;
  assign vi     = 16'({8'd0, a_item_q.row} * {7'd0, pp1[8:0]}) + {8'd0, a_item_q.col};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_item_q <= a_item_q;
      b_tu_q   <= a_tu_q;
      b_tv_q   <= a_tv_q;
      b_vi_q   <= vi;
      b_nr_q   <= vi + pp1[15:0];
      b_qv_q   <= (a_item_q.row < a_item_q.prec) && (a_item_q.col < a_item_q.prec);
      b_nx_q   <= sat(rsh(a_p1_q, 46), -17'sd16384, 17'sd16384);
      b_nz_q   <= sat(rsh(a_p2_q, 46), -17'sd16384, 17'sd16384);
      if (!a_item_q.mode) begin
        b_ny_q <= sat(rsh(-68'(a_c1_q), 16), -17'sd16384, 17'sd16384);
        b_py_q <= sat(rsh(-68'(a_c1_q), 18), -17'sd32768, 17'sd32767);
        b_px_q <= a_p1_q;
        b_pz_q <= a_p2_q;
      end else begin
        b_ny_q <= sat(rsh(68'(a_s2_q), 16), -17'sd16384, 17'sd16384);
        b_py_q <= sat(rsh(68'(a_rs_q), 30), -17'sd32768, 17'sd32767);
        b_px_q <= 68'($signed(w_r[33:0])) * 68'(a_c1_q);
        b_pz_q <= 68'($signed(w_r[33:0])) * 68'(a_s1_q);
      end
    end
  end

  // Stage C: final rounding of positions.
  logic [167:0] res_q;
  logic         qv_q;
  logic signed [15:0] px, pz;
  always_comb begin
    if (!b_item_q.mode) begin
      px = sat(rsh(b_px_q, 48), -17'sd32768, 17'sd32767);
      pz = sat(rsh(b_pz_q, 48), -17'sd32768, 17'sd32767);
    end else begin
      px = sat(rsh(b_px_q, 42), -17'sd32768, 17'sd32767);
      pz = sat(rsh(b_pz_q, 42), -17'sd32768, 17'sd32767);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= {6'd0, b_nr_q, b_vi_q, b_tv_q, b_tu_q,
                b_nz_q, b_ny_q, b_nx_q, pz, b_py_q, px};
      qv_q  <= b_qv_q;
    end
  end
  assign res_o = res_q;
  assign qv_o  = qv_q;

`ifndef ASSERT_OFF
  a_nr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> $isunknown(b_item_q) ||
             b_nr_q == 16'(b_vi_q + {8'd0, b_item_q.prec} + 16'd1))
    else $error("next row index mismatch");
  a_tu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> $isunknown(a_tu_q) || a_tu_q <= 17'd65536) else $error("tex u not saturated");
  a_qv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && b_qv_q |-> b_item_q.row < b_item_q.prec) else $error("quad flag wrong");
`endif
endmodule

// ===== rtl/parametric_mesh_vertex_generator.sv =====
// Top level: parametric mesh vertex generator (UV sphere and torus).
// A result passes from input transfer through the divider, then the CORDIC, then the
// output math, ending in the output register.
// Throughput: one grid point per cycle; the whole pipeline advances when the
// output register is free or being drained, set by the unrolled divider and CORDIC.
// Reset: asynchronous, active low; clears valid bits and restores register defaults.
module parametric_mesh_vertex_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // grid_row[7:0], grid_col[15:8]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                       // tex_u(17), tex_v(17), vertex_index,
                                       // next_row_index, zero pad
  output logic         m_axis_tuser,   // quad_valid
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [14:0]  cfg_data_i
);
  localparam int DivLat  = pmvg_pkg::DivSteps;
  localparam int CorLat  = pmvg_pkg::CordicSteps;
  localparam int ItemLat = DivLat + CorLat;
  localparam int Depth   = DivLat + CorLat + 3;

  logic        mode_q;
  logic [7:0]  prec_q;
  logic [14:0] inner_q, ring_q;

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      prec_q  <= 8'd32;
      inner_q <= 15'd8192;
      ring_q  <= 15'd2048;
    end else if (cfg_we_i) begin
      unique case ({2'b00, cfg_idx_i})
        pmvg_pkg::CfgShapeMode: mode_q  <= cfg_data_i[0];
        pmvg_pkg::CfgPrecision: prec_q  <= cfg_data_i[7:0];
        pmvg_pkg::CfgInnerRad:  inner_q <= cfg_data_i;
        default:                ring_q  <= cfg_data_i;
      endcase
    end
  end

  logic [7:0] p_eff;
  assign p_eff = (prec_q == 8'd0) ? 8'd1 : prec_q;

  // Pipeline advance: stall only when output holds an untaken result.
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  pmvg_pkg::item_t item_in;
  assign item_in = '{mode: mode_q, prec: p_eff, inner: inner_q, ring: ring_q,
                     row: s_axis_tdata[7:0], col: s_axis_tdata[15:8]};

  // Dividers: phases of row and column, texture coordinates.
  logic [23:0] q_row_ph, q_col_ph, q_tu;
  logic [23:0] n_row_ph;
  assign n_row_ph = mode_q ? {s_axis_tdata[7:0], 16'd0} >> 0
                           : {1'b0, s_axis_tdata[7:0], 15'd0};

  pmvg_div u_div_r (.clk_i, .rst_ni, .en_i(adv), .num_i(n_row_ph), .den_i(p_eff),
                    .quo_o(q_row_ph));
  pmvg_div u_div_c (.clk_i, .rst_ni, .en_i(adv), .num_i({s_axis_tdata[15:8], 16'd0}),
                    .den_i(p_eff), .quo_o(q_col_ph));
  assign q_tu = q_col_ph;

  // Item delay line alongside divider and CORDIC.
  pmvg_pkg::item_t item_q [ItemLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[0] <= item_in;
      for (int s = 1; s < ItemLat; s++) item_q[s] <= item_q[s-1];
    end
  end

  // Recompute exact tex v value; tu reuses the column quotient. tu/tv need full quotient, phases wrap to 16 bits.
  logic [23:0] tu_div, tv_div;
  pmvg_div u_div_tv (.clk_i, .rst_ni, .en_i(adv), .num_i({s_axis_tdata[7:0], 16'd0}),
                     .den_i(p_eff), .quo_o(tv_div));
  assign tu_div = q_tu;

  // Texture values delayed through the CORDIC span.
  logic [23:0] tu_q [CorLat];
  logic [23:0] tv_q [CorLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tu_q[0] <= tu_div;
      tv_q[0] <= tv_div;
      for (int s = 1; s < CorLat; s++) begin
        tu_q[s] <= tu_q[s-1];
        tv_q[s] <= tv_q[s-1];
      end
    end
  end

  logic signed [33:0] c1, s1, c2, s2;
  pmvg_cordic u_cor_r (.clk_i, .rst_ni, .en_i(adv), .phase_i({q_row_ph[15:0], 16'd0}),
                       .cos_o(c1), .sin_o(s1));
  pmvg_cordic u_cor_c (.clk_i, .rst_ni, .en_i(adv), .phase_i({q_col_ph[15:0], 16'd0}),
                       .cos_o(c2), .sin_o(s2));

  logic [167:0] res;
  logic         res_qv;
  pmvg_post u_post (.clk_i, .rst_ni, .en_i(adv), .item_i(item_q[ItemLat-1]),
                    .c1_i(c1), .s1_i(s1), .c2_i(c2), .s2_i(s2),
                    .tu_i(tu_q[CorLat-1]), .tv_i(tv_q[CorLat-1]), .res_o(res),
                    .qv_o(res_qv));

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = res;
  assign m_axis_tuser  = res_qv;

`ifndef ASSERT_OFF
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accepted while full");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[167:162] == 6'd0) else $error("pad bits set");
`endif
endmodule
